/* src/sm3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared constants, control bundles and bit functions of the SM3 engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUNDS  = 64;
  localparam int unsigned LEN_POS = 56;   // first byte of the length field

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  // Request to the message window
  typedef struct packed {
    logic       byte_shift;
    logic       word_shift;
    logic [7:0] data;
  } sched_ctl_t;

  // Request to the compression unit
  typedef struct packed {
    logic       init;
    logic       start;
    logic       round;
    logic       finish;
    logic [5:0] rnd;
    logic [2:0] sel;
  } comp_ctl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

  // Round constant rotated by the round number modulo 32
  function automatic logic [31:0] round_const(input logic [5:0] j);
    logic [31:0] t;
    t = (j < 6'd16) ? T_LOW : T_HIGH;
    return rotl32(t, j[4:0]);
  endfunction

endpackage
`default_nettype wire

/* src/sm3_sched.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_sched
// 64-byte block buffer that doubles as the 16-word expansion window.
// ----------------------------------------------------------------------------
module sm3_sched (
  input  wire                 clk,
  input  sm3_pkg::sched_ctl_t ctl,
  output logic [31:0]         w_j,
  output logic [31:0]         wp_j
);
  import sm3_pkg::*;

  logic [511:0] buf_r;
  logic [31:0]  win [16];
  logic [31:0]  w_new;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      win[k] = buf_r[511 - 32 * k -: 32];
    end
  end

  // Next expanded word from the current window, oldest word at tap 0
  assign w_new = perm1(win[0] ^ win[7] ^ rotl32(win[13], 5'd15))
               ^ rotl32(win[3], 5'd7) ^ win[10];

  assign w_j  = win[0];
  assign wp_j = win[0] ^ win[4];

  always_ff @(posedge clk) begin
    if (ctl.byte_shift) begin
      buf_r <= {buf_r[503:0], ctl.data};
    end else if (ctl.word_shift) begin
      buf_r <= {buf_r[479:0], w_new};
    end
  end

endmodule
`default_nettype wire

/* src/sm3_compress.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_round_core
// Chaining value and one-round-per-cycle SM3 compression unit.
// ----------------------------------------------------------------------------
module sm3_round_core (
  input  wire                clk,
  input  wire                rst_n,
  input  sm3_pkg::comp_ctl_t ctl,
  input  wire  [31:0]        w_j,
  input  wire  [31:0]        wp_j,
  output logic [31:0]        v_word
);
  import sm3_pkg::*;

  logic [31:0] v_r [8];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        early;

  assign early = ctl.rnd < 6'd16;
  assign a12   = rotl32(a_r, 5'd12);
  assign ss1   = rotl32(a12 + e_r + round_const(ctl.rnd), 5'd7);
  assign ss2   = ss1 ^ a12;
  assign ff    = early ? (a_r ^ b_r ^ c_r) : ((a_r & b_r) | (a_r & c_r) | (b_r & c_r));
  assign gg    = early ? (e_r ^ f_r ^ g_r) : ((e_r & f_r) | (~e_r & g_r));
  assign tt1   = ff + d_r + ss2 + wp_j;
  assign tt2   = gg + h_r + ss1 + w_j;

  assign v_word = v_r[ctl.sel];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      v_r <= IV;
    end else if (ctl.finish) begin
      v_r[0] <= v_r[0] ^ a_r;
      v_r[1] <= v_r[1] ^ b_r;
      v_r[2] <= v_r[2] ^ c_r;
      v_r[3] <= v_r[3] ^ d_r;
      v_r[4] <= v_r[4] ^ e_r;
      v_r[5] <= v_r[5] ^ f_r;
      v_r[6] <= v_r[6] ^ g_r;
      v_r[7] <= v_r[7] ^ h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= v_r[0];
      b_r <= v_r[1];
      c_r <= v_r[2];
      d_r <= v_r[3];
      e_r <= v_r[4];
      f_r <= v_r[5];
      g_r <= v_r[6];
      h_r <= v_r[7];
    end else if (ctl.round) begin
      d_r <= c_r;
      c_r <= rotl32(b_r, 5'd9);
      b_r <= a_r;
      a_r <= tt1;
      h_r <= g_r;
      g_r <= rotl32(f_r, 5'd19);
      f_r <= e_r;
      e_r <= perm0(tt2);
    end
  end

endmodule
`default_nettype wire

/* src/sm3_hash_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_engine
// Streaming SM3 hash: one message byte per request, eight digest words out.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  message_byte, byte_valid, end_of_message
//   out      output     out_valid/out_ready  digest_word, word_index, last_word
//
// A byte request is taken in S_IDLE; the byte that fills a block adds a load,
// 64 rounds on the shared round unit and a fold into the chaining value.
// End of message: pad to the block end and compress, plus a length-only block
// when n >= 56, then eight output words, one per accepted output request.
// Reset is synchronous; the engine is ready in the first cycle after it.
// Input is held off from a block-filling byte until the fold is done, and from
// an end of message until the last digest word leaves.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_message_byte,
  input  wire         in_byte_valid,
  input  wire         in_end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sm3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FINISH, S_PAD, S_OUT
  } state_t;

  state_t      state_r;
  logic [5:0]  cnt_r;
  logic [54:0] blocks_r;
  logic [5:0]  rnd_r;
  logic [2:0]  k_r;
  logic        pend_r;
  logic        pad_r;
  logic        mark_r;
  logic        len_blk_r;
  logic [63:0] len_r;

  logic        in_acc, out_acc;
  logic [5:0]  cnt_inc;
  logic [7:0]  pad_byte;
  logic        len_zone;
  sched_ctl_t  sched_ctl;
  comp_ctl_t   comp_ctl;
  logic [31:0] w_j, wp_j, v_word;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign cnt_inc   = cnt_r + 6'd1;

  assign len_zone = len_blk_r && (cnt_r >= 6'(LEN_POS));
  assign pad_byte = !mark_r ? PAD_MARK : (len_zone ? len_r[63:56] : 8'h00);

  always_comb begin
    sched_ctl.byte_shift = (in_acc && in_byte_valid) || (state_r == S_PAD);
    sched_ctl.word_shift = (state_r == S_ROUND);
    sched_ctl.data       = (state_r == S_PAD) ? pad_byte : in_message_byte;
  end

  always_comb begin
    comp_ctl.init   = out_acc && out_last_word;
    comp_ctl.start  = (state_r == S_START);
    comp_ctl.round  = (state_r == S_ROUND);
    comp_ctl.finish = (state_r == S_FINISH);
    comp_ctl.rnd    = rnd_r;
    comp_ctl.sel    = k_r;
  end

  sm3_sched u_sched (
    .clk  (clk),
    .ctl  (sched_ctl),
    .w_j  (w_j),
    .wp_j (wp_j)
  );

  sm3_round_core u_compress (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (comp_ctl),
    .w_j    (w_j),
    .wp_j   (wp_j),
    .v_word (v_word)
  );

  assign out_digest_word = v_word;
  assign out_word_index  = k_r;
  assign out_last_word   = (k_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      blocks_r  <= '0;
      rnd_r     <= '0;
      k_r       <= '0;
      pend_r    <= 1'b0;
      pad_r     <= 1'b0;
      mark_r    <= 1'b0;
      len_blk_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_byte_valid) begin
              cnt_r <= cnt_inc;
              if (cnt_r == 6'd63) begin
                blocks_r <= blocks_r + 55'd1;
                pend_r   <= in_end_of_message;
                state_r  <= S_START;
              end else if (in_end_of_message) begin
                // start padding after this byte
                state_r   <= S_PAD;
                pad_r     <= 1'b1;
                mark_r    <= 1'b0;
                len_r     <= {blocks_r, cnt_inc, 3'b000};
                len_blk_r <= (cnt_inc < 6'(LEN_POS));
              end
            end else if (in_end_of_message) begin
              state_r   <= S_PAD;
              pad_r     <= 1'b1;
              mark_r    <= 1'b0;
              len_r     <= {blocks_r, cnt_r, 3'b000};
              len_blk_r <= (cnt_r < 6'(LEN_POS));
            end
          end
        end
        S_START: begin
          rnd_r   <= '0;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(ROUNDS - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (pad_r) begin
            if (len_blk_r) begin
              k_r     <= '0;
              state_r <= S_OUT;
            end else begin
              // marker filled the block: follow with a length-only block
              len_blk_r <= 1'b1;
              state_r   <= S_PAD;
            end
          end else if (pend_r) begin
            pend_r    <= 1'b0;
            state_r   <= S_PAD;
            pad_r     <= 1'b1;
            mark_r    <= 1'b0;
            len_r     <= {blocks_r, cnt_r, 3'b000};
            len_blk_r <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          cnt_r  <= cnt_inc;
          mark_r <= 1'b1;
          if (mark_r && len_zone) begin
            len_r <= {len_r[55:0], 8'h00};
          end
          if (cnt_r == 6'd63) begin
            state_r <= S_START;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            k_r <= k_r + 3'd1;
            if (out_last_word) begin
              state_r  <= S_IDLE;
              pad_r    <= 1'b0;
              blocks_r <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_byte_valid && cnt_r == 6'd63) |=> (state_r == S_START))
    else $error("full block did not start compression");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'(ROUNDS - 1)) |=> (state_r == S_FINISH))
    else $error("round count overran");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_word) |=> (in_ready && cnt_r == 6'd0 && blocks_r == 55'd0))
    else $error("engine not cleared after digest");
`endif

endmodule
`default_nettype wire

/* bench/sm3_digest_checker.sv */
// ----------------------------------------------------------------------------
// sm3_digest_checker
// Watches both channels of the SM3 engine, hashes every accepted request in
// its own model and compares each digest word with the oldest one predicted.
// ----------------------------------------------------------------------------
module sm3_digest_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [7:0]  in_message_byte,
  input  wire        in_byte_valid,
  input  wire        in_end_of_message,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [31:0] out_digest_word,
  input  wire [2:0]  out_word_index,
  input  wire        out_last_word,
  output int         errors,
  output int         pending
);

  localparam logic [31:0] START_VALUE [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };
  localparam logic [31:0] ROUND_K_LOW  = 32'h79CC4519;
  localparam logic [31:0] ROUND_K_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q [$];
  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [54:0]  nblocks;
  int           mismatches = 0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    int unsigned k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] mix0(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] mix1(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // Compress blk into the chaining value
  function automatic void fold_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? ROUND_K_LOW : ROUND_K_HIGH;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol(f, 19);
      f = e;
      e = mix0(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endfunction

  // Absorb one request; on end of message pad, finish and queue the digest
  function automatic void absorb_request(input logic [7:0] data, input logic has_byte,
                                         input logic last);
    logic [63:0] bitlen;
    int unsigned n;
    digest_word_t dw;
    if (has_byte) begin
      blk[fill] = data;
      fill++;
      if (fill == 64) begin
        fold_block();
        nblocks++;
        fill = 0;
      end
    end
    if (!last) return;
    n = fill;
    bitlen = {nblocks, 9'd0} + (64'(n) << 3);
    blk[n] = PAD_BYTE;
    for (int i = n + 1; i < 64; i++) blk[i] = 8'h00;
    // no room for the length: spill into a second block
    if (n + 9 > 64) begin
      fold_block();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = bitlen[63-8*i -: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = chain[i];
      dw.idx  = 3'(i);
      dw.last = (i == 7);
      digest_q.push_back(dw);
    end
    chain   = START_VALUE;
    fill    = 0;
    nblocks = '0;
  endfunction

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      chain   = START_VALUE;
      fill    = 0;
      nblocks = '0;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0d",
                   $time, out_digest_word, out_word_index, out_last_word);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word || out_word_index !== want.idx ||
              out_last_word !== want.last) begin
            mismatches++;
            $display("%0t: digest mismatch: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                     $time, want.word, want.idx, want.last,
                     out_digest_word, out_word_index, out_last_word);
          end
        end
      end
      if (in_valid && in_ready)
        absorb_request(in_message_byte, in_byte_valid, in_end_of_message);
    end
    errors  <= mismatches;
    pending <= digest_q.size();
  end

endmodule

/* bench/sm3_hash_engine_tb.sv */
// ----------------------------------------------------------------------------
// sm3_hash_engine_tb
// Feeds the SM3 engine directed and random messages byte by byte, with random
// stalls on both channels; the checker beside the engine judges every word.
// ----------------------------------------------------------------------------
module sm3_hash_engine_tb;

  localparam int unsigned ITEM_TARGET  = 280;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int          errors;
  int          pending;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned msgs_sent = 0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sm3_hash_engine DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  sm3_digest_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_byte   (in_message_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .errors            (errors),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sm3_hash_engine_tb: errors");
      $finish;
    end
  end

  // Digest side: random ready bursts, one long hold-off, steady at the end
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!hold_done && msgs_sent >= 2) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [7:0] data, input logic has_byte,
                              input logic last);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_message_byte   <= data;
    in_byte_valid     <= has_byte;
    in_end_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has_byte || last) items_sent++;
    if (last) msgs_sent++;
  endtask

  // Random bytes with the odd ignored request mixed in
  task automatic send_message(input int unsigned len, input bit bare_end);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned edge_lens [7] = '{55, 56, 63, 64, 65, 119, 120};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_request(8'hA5, 1'b0, 1'b0);   // ignored
    send_request(8'h00, 1'b0, 1'b1);   // empty message
    send_request(8'h61, 1'b1, 1'b0);   // "abc", end with the last byte
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);   // two bytes, bare end
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);   // ignored
    send_request(8'hFF, 1'b1, 1'b1);   // single byte with end

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET * 4 / 5) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 12);
      else len = edge_lens[$urandom_range(0, 6)];
      // keep the total close to the target
      if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
      send_message(len, $urandom_range(0, 1));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("sm3_hash_engine_tb: clean");
    else
      $display("sm3_hash_engine_tb: errors");
    $finish;
  end

endmodule
